// File: hdl/spf_pkg.sv
// Shared types and constants for the sensor packet framer.
// No dependencies; imported by every module of the framer.
package spf_pkg;

   // Item kinds as carried on req_type
   localparam logic [1:0] KIND_BEGIN = 2'd0;
   localparam logic [1:0] KIND_DATA  = 2'd1;
   localparam logic [1:0] KIND_END   = 2'd2;
   localparam logic [1:0] KIND_NONE  = 2'd3;

   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [7:0]  CI_BYTE  = 8'h08;

   // Classified work for the back end
   typedef struct packed {
      logic [1:0]  kind;
      logic        three;   // data: three bytes rather than two
      logic [23:0] value;   // data: offset sum; begin: {8'h0, len-1, mask}
   } cmd_type;

   // One packet byte on its way out
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       pend;
   } out_type;

endpackage

// File: hdl/spf_front.sv
// Front end: holds the sensor mask, classifies request beats and queues commands.
// Depends on spf_pkg.
module spf_front
   import spf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   input  logic [1:0]         req_type,
   input  logic signed [23:0] reading_value,
   input  logic [1:0]         offset_select,
   input  logic               three_bytes,
   input  logic               csr_we,
   input  logic [7:0]         csr_wdata,
   output logic               req_full,
   output logic               cmd_valid,
   output cmd_type            cmd,
   input  logic               cmd_pop
);

   // Bytes contributed by each presence bit
   localparam logic [5:0] BYTES_PER_BIT [8] = '{6'd6, 6'd4, 6'd4, 6'd4,
                                                6'd4, 6'd6, 6'd4, 6'd2};

   logic [7:0]  mask_ff;
   cmd_type     q_ff [2];
   logic        wr_ptr_ff, rd_ptr_ff;
   logic [1:0]  count_ff;
   logic [5:0]  body_bytes;
   logic [7:0]  len_m1;
   logic [23:0] offset;
   cmd_type     new_cmd;
   logic        accept, push;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= 8'h00;
      end else if (csr_we) begin
         mask_ff <= csr_wdata;
      end
   end

   // Packet length from the presence mask
   always_comb begin
      body_bytes = 6'd0;
      for (int i = 0; i < 8; i++) begin
         if (mask_ff[i]) begin
            body_bytes = body_bytes + BYTES_PER_BIT[i];
         end
      end
      len_m1 = {2'b00, body_bytes} + 8'd6;
   end

   // Offset selection
   always_comb begin
      case (offset_select)
         2'd0:    offset = 24'd0;
         2'd1:    offset = 24'd18000;
         2'd2:    offset = 24'd10000;
         default: offset = 24'd30000;
      endcase
   end

   // Classify the beat
   always_comb begin
      new_cmd.kind  = req_type;
      new_cmd.three = three_bytes;
      if (req_type == KIND_DATA) begin
         new_cmd.value = reading_value + offset;
      end else begin
         new_cmd.value = {8'h00, len_m1, mask_ff};
      end
   end

   assign req_full  = (count_ff == 2'd2);
   assign accept    = req_push && !req_full;
   // Unknown kinds are taken and dropped
   assign push      = accept && (req_type != KIND_NONE);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];

   // Two-entry command queue
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (cmd_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (push && !cmd_pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (!push && cmd_pop) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

endmodule

// File: hdl/spf_back.sv
// Back end: steps a command one byte a cycle unless out_full, keeping the running CRC.
// Depends on spf_pkg.
module spf_back
   import spf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   input  cmd_type cmd,
   output logic    cmd_pop,
   input  logic    out_full,
   output logic    out_push,
   output out_type out_beat
);

   logic [15:0] crc_ff, crc_in;
   logic [2:0]  step_ff, step_in;
   logic [15:0] crc_base;
   logic [7:0]  fed;
   logic        upd, emit, fin, advance;
   logic [1:0]  sel;

   // One byte of CRC-16/CCITT, MSB first
   function automatic logic [15:0] crc_feed(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] v;
      v = c ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         v = v[15] ? ({v[14:0], 1'b0} ^ CRC_POLY) : {v[14:0], 1'b0};
      end
      return v;
   endfunction

   // Byte selection per command kind and step
   always_comb begin
      fed           = 8'h00;
      upd           = 1'b0;
      emit          = 1'b0;
      fin           = 1'b0;
      crc_base      = crc_ff;
      out_beat.data = 8'h00;
      out_beat.pend = 1'b0;
      sel           = step_ff[1:0] + {1'b0, ~cmd.three};
      case (cmd.kind)
         KIND_BEGIN: begin
            case (step_ff)
               3'd0, 3'd2: fed = cmd.value[15:8];
               3'd1, 3'd3: fed = CI_BYTE;
               default:    fed = cmd.value[7:0];
            endcase
            if (step_ff == 3'd0) begin
               crc_base = CRC_INIT;
            end
            upd           = 1'b1;
            emit          = 1'b1;
            fin           = (step_ff == 3'd4);
            out_beat.data = fed;
         end
         KIND_DATA: begin
            case (sel)
               2'd0:    fed = cmd.value[23:16];
               2'd1:    fed = cmd.value[15:8];
               default: fed = cmd.value[7:0];
            endcase
            upd           = 1'b1;
            emit          = 1'b1;
            fin           = (sel == 2'd2);
            out_beat.data = fed;
         end
         KIND_END: begin
            // two zero bytes into the CRC, then the CRC itself
            case (step_ff)
               3'd0, 3'd1: upd = 1'b1;
               3'd2: begin
                  emit          = 1'b1;
                  out_beat.data = crc_ff[15:8];
               end
               default: begin
                  emit          = 1'b1;
                  fin           = 1'b1;
                  out_beat.data = crc_ff[7:0];
                  out_beat.pend = 1'b1;
               end
            endcase
         end
         default: fin = 1'b1;
      endcase
      out_beat.last = fin;
   end

   assign advance  = cmd_valid && !out_full;
   assign out_push = advance && emit;
   assign cmd_pop  = advance && fin;
   assign crc_in   = (advance && upd) ? crc_feed(crc_base, fed) : crc_ff;
   assign step_in  = !advance ? step_ff : (fin ? 3'd0 : step_ff + 3'd1);

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff  <= CRC_INIT;
         step_ff <= 3'd0;
      end else begin
         crc_ff  <= crc_in;
         step_ff <= step_in;
      end
   end

endmodule

// File: hdl/spf_outq.sv
// Result queue: two-entry buffer between the back end and the rsp_ port.
// Depends on spf_pkg.
module spf_outq
   import spf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  out_type beat_in,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output out_type beat_out
);

   out_type    q_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign do_pop   = pop && !empty;
   assign beat_out = q_ff[rd_ptr_ff];

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= beat_in;
      end
   end

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (push && !do_pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (!push && do_pop) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

endmodule

// File: hdl/sensor_packet_framer_crc16.sv
// Sensor packet framer with a CRC-16/CCITT trailer (init FFFF, two zero bytes fed in
// before the CRC is sent); uses spf_pkg, spf_front, spf_back and spf_outq. The first
// byte of a request beat reaches the rsp_ ports through the command queue and the
// result queue registers. The back end's byte sequencer emits a begin as five bytes,
// a data beat as two or three and an end as two CRC bytes; request beats queue two deep.
// Reset (synchronous, active high) empties both queues, clears the mask, CRC to FFFF.
module sensor_packet_framer_crc16
   import spf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [1:0]         req_type,
   input  logic signed [23:0] req_reading_value,
   input  logic [1:0]         req_offset_select,
   input  logic               req_three_bytes,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_run_last,
   output logic               rsp_packet_end,
   input  logic               csr_we,
   input  logic [7:0]         csr_wdata
);

   logic    cmd_valid, cmd_pop, out_full, out_push;
   cmd_type cmd;
   out_type out_beat, head;

   spf_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_type      (req_type),
      .reading_value (req_reading_value),
      .offset_select (req_offset_select),
      .three_bytes   (req_three_bytes),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .req_full      (req_full),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_pop       (cmd_pop)
   );

   spf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_beat  (out_beat)
   );

   spf_outq u_outq (
      .clock    (clock),
      .reset    (reset),
      .push     (out_push),
      .beat_in  (out_beat),
      .full     (out_full),
      .pop      (rsp_pop),
      .empty    (rsp_empty),
      .beat_out (head)
   );

   assign rsp_out_byte   = head.data;
   assign rsp_run_last   = head.last;
   assign rsp_packet_end = head.pend;

endmodule
